### rtl/core/fds_pkg.sv
// ----------------------------------------------------------------------------
// fds_pkg
// Shared types and constants of the directory entry scanner.
// ----------------------------------------------------------------------------
package fds_pkg;

   localparam int DEF_ENTRIES_PER_SECTOR = 16;
   localparam int NAME_LEN               = 11;
   localparam int NAME_BITS              = 8 * NAME_LEN;

   localparam logic [7:0] DELETED_MARK = 8'hE5;
   localparam logic [7:0] ORDER_MAX    = 8'h42;
   localparam logic [7:0] ATTR_LONG    = 8'h0F;
   localparam logic [7:0] ATTR_DIR     = 8'h10;
   localparam logic [7:0] ATTR_VOL     = 8'h08;

   localparam logic [4:0] POS_ATTR   = 5'd11;
   localparam logic [4:0] POS_CLS_2  = 5'd20;
   localparam logic [4:0] POS_CLS_3  = 5'd21;
   localparam logic [4:0] POS_CLS_0  = 5'd26;
   localparam logic [4:0] POS_CLS_1  = 5'd27;
   localparam logic [4:0] POS_SIZE_0 = 5'd28;
   localparam logic [4:0] POS_LAST   = 5'd31;

   localparam logic [63:0] RST_NAME_HEAD = 64'h5445_5854_2020_2020;
   localparam logic [23:0] RST_NAME_TAIL = 24'h54_5854;
   localparam logic [31:0] RST_PART      = 32'd0;
   localparam logic [15:0] RST_RESERVED  = 16'd32;
   localparam logic [31:0] RST_FAT_LEN   = 32'd0;
   localparam logic [7:0]  RST_FAT_COPY  = 8'd2;
   localparam logic [7:0]  RST_CLS_SECT  = 8'd8;

   typedef enum logic [2:0] {
      KIND_LONG = 3'd0,
      KIND_FILE = 3'd1,
      KIND_DIR  = 3'd2,
      KIND_VOL  = 3'd3,
      KIND_BAD  = 3'd4,
      KIND_END  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      CSR_NAME_HEAD = 3'd0,
      CSR_NAME_TAIL = 3'd1,
      CSR_PART      = 3'd2,
      CSR_RESERVED  = 3'd3,
      CSR_FAT_LEN   = 3'd4,
      CSR_FAT_COPY  = 3'd5,
      CSR_CLS_SECT  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [NAME_BITS-1:0] name;         // byte zero in top bits
      logic [7:0]           cluster_sectors;
      logic [31:0]          base;         // first sector of cluster two
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic        hit;
      logic [31:0] cluster;
      logic [31:0] length;
      logic [31:0] offset;                // (cluster - 2) * cluster_sectors
   } entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic        hit;
      logic [31:0] cluster;
      logic [31:0] length;
      logic [31:0] sector;
   } result_type;

endpackage

### rtl/core/fds_csr.sv
// ----------------------------------------------------------------------------
// fds_csr
// Configuration registers and the precomputed data region base sector.
// ----------------------------------------------------------------------------
module fds_csr
   import fds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output cfg_type     cfg
);

   logic [63:0] head_ff;
   logic [23:0] tail_ff;
   logic [31:0] part_ff;
   logic [15:0] reserved_ff;
   logic [31:0] fat_len_ff;
   logic [7:0]  fat_copy_ff;
   logic [7:0]  cls_sect_ff;
   logic [31:0] fat_prod_ff;
   logic [31:0] base_ff;
   logic [39:0] fat_prod_in;
   logic [31:0] base_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= RST_NAME_HEAD;
         tail_ff     <= RST_NAME_TAIL;
         part_ff     <= RST_PART;
         reserved_ff <= RST_RESERVED;
         fat_len_ff  <= RST_FAT_LEN;
         fat_copy_ff <= RST_FAT_COPY;
         cls_sect_ff <= RST_CLS_SECT;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_NAME_HEAD: head_ff     <= csr_data;
            CSR_NAME_TAIL: tail_ff     <= csr_data[23:0];
            CSR_PART:      part_ff     <= csr_data[31:0];
            CSR_RESERVED:  reserved_ff <= csr_data[15:0];
            CSR_FAT_LEN:   fat_len_ff  <= csr_data[31:0];
            CSR_FAT_COPY:  fat_copy_ff <= csr_data[7:0];
            CSR_CLS_SECT:  cls_sect_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // base follows the registers through the registered FAT product and the base register
   assign fat_prod_in = 40'(fat_copy_ff) * 40'(fat_len_ff);
   assign base_in     = part_ff + 32'(reserved_ff) + fat_prod_ff;

   always_ff @(posedge clock) begin
      fat_prod_ff <= fat_prod_in[31:0];
      base_ff     <= base_in;
   end

   assign cfg.name            = {head_ff, tail_ff};
   assign cfg.cluster_sectors = cls_sect_ff;
   assign cfg.base            = base_ff;

endmodule

### rtl/core/fds_parse.sv
// ----------------------------------------------------------------------------
// fds_parse
// Input register, per-byte scan state and entry classification stage.
// ----------------------------------------------------------------------------
module fds_parse
   import fds_pkg::*;
#(
   parameter int ENTRIES_PER_SECTOR = DEF_ENTRIES_PER_SECTOR
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  logic [7:0] in_byte,
   input  logic      in_begin,
   input  cfg_type   cfg,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   localparam int CW = $clog2(ENTRIES_PER_SECTOR + 1);

   // input register
   logic       a_valid_ff;
   logic [7:0] a_byte_ff;
   logic       a_begin_ff;

   // scan state
   logic [4:0]    pos_ff,     pos_in,     cur_pos;
   logic [3:0]    slot_ff,    slot_in,    cur_slot;
   logic [CW-1:0] done_ff,    done_in,    cur_done;
   logic [7:0]    order_ff,   order_in,   cur_order;
   logic [7:0]    attr_ff,    attr_in,    cur_attr;
   logic [31:0]   cluster_ff, cluster_in, cur_cluster;
   logic [31:0]   size_ff,    size_in,    cur_size;
   logic          equal_ff,   equal_in,   cur_equal;
   logic          run_ff,     run_in,     cur_run;
   logic          stop_ff,    stop_in,    cur_stop;

   logic       b_valid_ff;
   entry_type  b_entry_ff;
   entry_type  entry_in;
   logic       emit;
   logic       b_ready;
   logic       take_a;
   logic       ord_ok;
   kind_type   kind;
   logic [7:0] tgt [NAME_LEN];
   logic [39:0] offset_full;

   assign b_ready  = !b_valid_ff || out_ready;
   assign take_a   = a_valid_ff && b_ready;
   assign in_ready = !a_valid_ff || b_ready;

   always_comb begin
      for (int k = 0; k < NAME_LEN; k++) begin
         tgt[k] = cfg.name[8*(NAME_LEN-1-k) +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_byte_ff  <= in_byte;
         a_begin_ff <= in_begin;
      end
   end

   always_comb begin
      // a sector mark restarts the scan before its byte is taken
      if (a_begin_ff) begin
         cur_pos = '0; cur_slot = '0; cur_done = '0; cur_order = '0; cur_attr = '0;
         cur_cluster = '0; cur_size = '0; cur_equal = 1'b1; cur_run = 1'b0;
         cur_stop = 1'b0;
      end else begin
         cur_pos = pos_ff; cur_slot = slot_ff; cur_done = done_ff; cur_order = order_ff;
         cur_attr = attr_ff; cur_cluster = cluster_ff; cur_size = size_ff;
         cur_equal = equal_ff; cur_run = run_ff; cur_stop = stop_ff;
      end

      pos_in = cur_pos; slot_in = cur_slot; done_in = cur_done; order_in = cur_order;
      attr_in = cur_attr; cluster_in = cur_cluster; size_in = cur_size;
      equal_in = cur_equal; run_in = cur_run; stop_in = cur_stop;
      emit = 1'b0;
      kind = KIND_END;
      ord_ok = cur_order inside {[8'd1:ORDER_MAX]};

      if (!cur_stop) begin
         if (cur_pos == '0) begin
            order_in = a_byte_ff;
         end
         if (cur_pos < 5'(NAME_LEN)) begin
            if (a_byte_ff != tgt[cur_pos[3:0]]) begin
               equal_in = 1'b0;
            end
         end
         if (cur_pos == POS_ATTR)  attr_in = a_byte_ff;
         if (cur_pos == POS_CLS_2) cluster_in[23:16] = a_byte_ff;
         if (cur_pos == POS_CLS_3) cluster_in[31:24] = a_byte_ff;
         if (cur_pos == POS_CLS_0) cluster_in[7:0]   = a_byte_ff;
         if (cur_pos == POS_CLS_1) cluster_in[15:8]  = a_byte_ff;
         if (cur_pos >= POS_SIZE_0) begin
            size_in[{cur_pos[1:0], 3'b000} +: 8] = a_byte_ff;
         end

         if (cur_pos != POS_LAST) begin
            pos_in = cur_pos + 5'd1;
         end else begin
            emit = 1'b1;
            if (cur_run && ord_ok) begin
               kind = KIND_LONG;
            end else begin
               run_in = 1'b0;
               if (cur_attr == ATTR_LONG && ord_ok && cur_order != DELETED_MARK) begin
                  kind   = KIND_LONG;
                  run_in = 1'b1;
               end else if (cur_order == 8'd0) begin
                  kind = KIND_END;
               end else begin
                  case (cur_attr & (ATTR_DIR | ATTR_VOL))
                     8'h00:    kind = KIND_FILE;
                     ATTR_DIR: kind = KIND_DIR;
                     ATTR_VOL: kind = KIND_VOL;
                     default:  kind = KIND_BAD;
                  endcase
               end
            end
            if (kind == KIND_END || kind == KIND_BAD) begin
               stop_in = 1'b1;
            end
            pos_in   = '0;
            equal_in = 1'b1;
            slot_in  = cur_slot + 4'd1;
            done_in  = cur_done + CW'(1);
            if (done_in == CW'(ENTRIES_PER_SECTOR)) begin
               stop_in = 1'b1;
            end
         end
      end

      // cluster bytes are complete by the last byte of the entry
      offset_full = 40'(cur_cluster - 32'd2) * 40'(cfg.cluster_sectors);

      entry_in = '0;
      entry_in.kind = kind;
      entry_in.slot = cur_slot;
      if (kind == KIND_FILE) begin
         entry_in.hit     = cur_equal;
         entry_in.cluster = cur_cluster;
         entry_in.length  = size_in;
         entry_in.offset  = offset_full[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         slot_ff    <= '0;
         done_ff    <= '0;
         order_ff   <= '0;
         attr_ff    <= '0;
         cluster_ff <= '0;
         size_ff    <= '0;
         equal_ff   <= 1'b1;
         run_ff     <= 1'b0;
         stop_ff    <= 1'b0;
      end else if (take_a) begin
         pos_ff     <= pos_in;
         slot_ff    <= slot_in;
         done_ff    <= done_in;
         order_ff   <= order_in;
         attr_ff    <= attr_in;
         cluster_ff <= cluster_in;
         size_ff    <= size_in;
         equal_ff   <= equal_in;
         run_ff     <= run_in;
         stop_ff    <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= take_a && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (take_a && emit) begin
         b_entry_ff <= entry_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_entry = b_entry_ff;

endmodule

### rtl/core/fds_out.sv
// ----------------------------------------------------------------------------
// fds_out
// Result register: adds the data region base to the cluster offset of file entries.
// ----------------------------------------------------------------------------
module fds_out
   import fds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  entry_type   in_entry,
   input  logic [31:0] base,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_result
);

   logic       valid_ff;
   result_type result_ff;
   result_type result_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      result_in.kind    = in_entry.kind;
      result_in.slot    = in_entry.slot;
      result_in.hit     = in_entry.hit;
      result_in.cluster = in_entry.cluster;
      result_in.length  = in_entry.length;
      result_in.sector  = (in_entry.kind == KIND_FILE) ? base + in_entry.offset : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

### rtl/core/fat32_directory_entry_scanner.sv
// ----------------------------------------------------------------------------
// fat32_directory_entry_scanner
// Classifies the 32-byte entries of a FAT32 directory sector streamed bytewise.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req_     in         one directory byte, sector start flag
//  rsp_     out        one result per completed 32-byte entry
//  csr_     in         register index and write data
//
//  one byte is accepted every cycle while req_tready is high; a result passes from the
//  last byte of its entry through the input register, classify stage and result register
//  bytes keep flowing while one result waits behind a stalled rsp_ side; once a
//  second result sits in the classify stage the next byte holds req_ off
//  reset clears the scan state and loads the register defaults; no sweep
//  the data region base is precomputed from the registers through the FAT product and base registers
module fat32_directory_entry_scanner
   import fds_pkg::*;
#(
   parameter int ENTRIES_PER_SECTOR = DEF_ENTRIES_PER_SECTOR
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // dir_byte
   input  logic [0:0]   req_tuser,   // sector_begin
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // entry_slot[3:0], name_hit[4], start_cluster[36:5], byte_length[68:37],
   // first_data_sector[100:69], zero pad[103:101]
   output logic [103:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // entry_kind
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   cfg_type    cfg;
   entry_type  entry;
   logic       entry_valid;
   logic       entry_ready;
   result_type result;

   fds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fds_parse #(
      .ENTRIES_PER_SECTOR (ENTRIES_PER_SECTOR)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_begin  (req_tuser[0]),
      .cfg       (cfg),
      .out_valid (entry_valid),
      .out_ready (entry_ready),
      .out_entry (entry)
   );

   fds_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (entry_valid),
      .in_ready   (entry_ready),
      .in_entry   (entry),
      .base       (cfg.base),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tdata = {3'b000, result.sector, result.length, result.cluster,
                       result.hit, result.slot};

`ifndef ASSERT_OFF
   // only file entries carry payload above the slot
   a_nonfile_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_FILE) |-> (rsp_tdata[103:4] == 100'd0))
      else $error("non-file result carries payload");

   // an empty result register never holds back the byte stream
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a queued entry moves on as soon as the result register frees up
   a_entry_drains: assert property (@(posedge clock) disable iff (reset)
      (entry_valid && !rsp_tvalid) |=> rsp_tvalid)
      else $error("classified entry did not reach the output");
`endif

endmodule

### verif/fat32_directory_entry_scanner_tb.sv
// ----------------------------------------------------------------------------
// fat32_directory_entry_scanner_tb
// Streams directory sectors byte by byte into the scanner, predicts every
// entry result with a cycle-free model of the entry rules and compares the
// results in order. Runs directed entries first, then random sectors under
// several register settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module fat32_directory_entry_scanner_tb;
   import fds_pkg::*;

   localparam logic [7:0] ATTR_PLAIN  = 8'h20;
   localparam int         HOLD_CYCLES = 300;
   localparam int         PHASE_ITEMS = 160;

   typedef logic [0:31][7:0] raw_entry_type;

   typedef struct packed {
      logic       sof;
      logic [7:0] data;
   } dir_item_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;
   logic [0:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index  = CSR_NAME_HEAD;
   logic [63:0]  csr_data   = '0;

   fat32_directory_entry_scanner uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // register copies
   logic [63:0] cf_head;
   logic [23:0] cf_tail;
   logic [31:0] cf_part;
   logic [15:0] cf_reserved;
   logic [31:0] cf_fat_len;
   logic [7:0]  cf_fat_copies;
   logic [7:0]  cf_cls_sect;

   // scan state
   logic [4:0]  sc_pos;
   logic [3:0]  sc_slot;
   logic [7:0]  sc_order;
   logic [7:0]  sc_attr;
   logic [31:0] sc_cluster;
   logic [31:0] sc_size;
   logic        sc_name_eq;
   logic        sc_in_run;
   logic        sc_stopped;
   int          sc_entries;

   dir_item_type byte_q[$];
   result_type   entry_q[$];
   int           items_sent    = 0;
   int           error_count   = 0;
   logic         req_fire      = 1'b0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           rsp_hold_seq  = 0;
   int           hold_seen     = 0;
   int           hold_left     = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] target_byte(int k);
      if (k < 8) return cf_head[63 - 8*k -: 8];
      return cf_tail[23 - 8*(k - 8) -: 8];
   endfunction

   task automatic restart_scan();
      sc_pos     = '0;
      sc_slot    = '0;
      sc_entries = 0;
      sc_order   = '0;
      sc_attr    = '0;
      sc_cluster = '0;
      sc_size    = '0;
      sc_name_eq = 1'b1;
      sc_in_run  = 1'b0;
      sc_stopped = 1'b0;
   endtask

   task automatic reset_predictor();
      cf_head       = RST_NAME_HEAD;
      cf_tail       = RST_NAME_TAIL;
      cf_part       = RST_PART;
      cf_reserved   = RST_RESERVED;
      cf_fat_len    = RST_FAT_LEN;
      cf_fat_copies = RST_FAT_COPY;
      cf_cls_sect   = RST_CLS_SECT;
      restart_scan();
   endtask

   task automatic apply_csr(csr_index_type idx, logic [63:0] v);
      case (idx)
         CSR_NAME_HEAD: cf_head       = v;
         CSR_NAME_TAIL: cf_tail       = v[23:0];
         CSR_PART:      cf_part       = v[31:0];
         CSR_RESERVED:  cf_reserved   = v[15:0];
         CSR_FAT_LEN:   cf_fat_len    = v[31:0];
         CSR_FAT_COPY:  cf_fat_copies = v[7:0];
         CSR_CLS_SECT:  cf_cls_sect   = v[7:0];
         default: ;
      endcase
   endtask

   // advances the scan by one byte, queues the entry result on byte 31
   task automatic scan_byte(input logic [7:0] b, input logic sof);
      logic        ord_ok;
      kind_type    kind;
      result_type  r;
      logic [31:0] base;
      if (sof) restart_scan();
      if (sc_stopped) return;
      if (sc_pos == 5'd0) sc_order = b;
      if (sc_pos < NAME_LEN && b != target_byte(sc_pos)) sc_name_eq = 1'b0;
      case (sc_pos)
         POS_ATTR:  sc_attr           = b;
         POS_CLS_2: sc_cluster[23:16] = b;
         POS_CLS_3: sc_cluster[31:24] = b;
         POS_CLS_0: sc_cluster[7:0]   = b;
         POS_CLS_1: sc_cluster[15:8]  = b;
         default: ;
      endcase
      if (sc_pos >= POS_SIZE_0) sc_size[8*(sc_pos - POS_SIZE_0) +: 8] = b;
      if (sc_pos != POS_LAST) begin
         sc_pos++;
         return;
      end

      ord_ok = sc_order >= 8'd1 && sc_order <= ORDER_MAX;
      if (sc_in_run && ord_ok) begin
         kind = KIND_LONG;
      end else begin
         sc_in_run = 1'b0;
         if (sc_attr == ATTR_LONG && ord_ok && sc_order != DELETED_MARK) begin
            kind      = KIND_LONG;
            sc_in_run = 1'b1;
         end else if (sc_order == 8'd0) begin
            kind = KIND_END;
         end else begin
            case (sc_attr & (ATTR_DIR | ATTR_VOL))
               ATTR_DIR:            kind = KIND_DIR;
               ATTR_VOL:            kind = KIND_VOL;
               ATTR_DIR | ATTR_VOL: kind = KIND_BAD;
               default:             kind = KIND_FILE;
            endcase
         end
      end

      r      = '0;
      r.kind = kind;
      r.slot = sc_slot;
      if (kind == KIND_FILE) begin
         base      = cf_part + 32'(cf_reserved) + 32'(cf_fat_copies) * cf_fat_len;
         r.hit     = sc_name_eq;
         r.cluster = sc_cluster;
         r.length  = sc_size;
         r.sector  = base + (sc_cluster - 32'd2) * 32'(cf_cls_sect);
      end
      entry_q.push_back(r);

      if (kind == KIND_END || kind == KIND_BAD) sc_stopped = 1'b1;
      sc_pos     = '0;
      sc_name_eq = 1'b1;
      sc_slot++;
      sc_entries++;
      if (sc_entries >= DEF_ENTRIES_PER_SECTOR) sc_stopped = 1'b1;
   endtask

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         error_count++;
      end
   endfunction

   task automatic check_entry();
      result_type want;
      if (entry_q.size() == 0) begin
         $error("entry result with nothing pending: kind %0d slot %0d",
                rsp_tuser, rsp_tdata[3:0]);
         error_count++;
         return;
      end
      want = entry_q.pop_front();
      check_field("entry_kind",        32'(want.kind),  32'(rsp_tuser));
      check_field("entry_slot",        32'(want.slot),  32'(rsp_tdata[3:0]));
      check_field("name_hit",          32'(want.hit),   32'(rsp_tdata[4]));
      check_field("start_cluster",     want.cluster,    rsp_tdata[36:5]);
      check_field("byte_length",       want.length,     rsp_tdata[68:37]);
      check_field("first_data_sector", want.sector,     rsp_tdata[100:69]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_predictor();
         req_fire <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) apply_csr(csr_index_type'(csr_index), csr_data);
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) check_entry();
         req_fire <= req_tvalid && req_tready;
      end
   end

   always @(negedge clock) begin : drive_req
      dir_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = byte_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.data;
            req_tuser  <= it.sof;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != rsp_hold_seq) begin
         // long stall so the pipeline fills and req_tready drops
         hold_seen  <= rsp_hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= rsp_stall_pct;
      end
   end

   function automatic raw_entry_type build_entry(logic [7:0] order, logic [7:0] attr,
                                                logic [31:0] cluster, logic [31:0] size);
      raw_entry_type e;
      for (int k = 0; k < 32; k++) e[k] = 8'($urandom);
      e[0]         = order;
      e[POS_ATTR]  = attr;
      e[POS_CLS_2] = cluster[23:16];
      e[POS_CLS_3] = cluster[31:24];
      e[POS_CLS_0] = cluster[7:0];
      e[POS_CLS_1] = cluster[15:8];
      for (int k = 0; k < 4; k++) e[POS_SIZE_0 + k] = size[8*k +: 8];
      return e;
   endfunction

   function automatic raw_entry_type with_target_name(raw_entry_type e);
      for (int k = 0; k < NAME_LEN; k++) e[k] = target_byte(k);
      return e;
   endfunction

   function automatic logic [7:0] pick_order();
      case ($urandom_range(9))
         0:       return DELETED_MARK;
         1, 2:    return 8'($urandom_range(1, 255));
         default: return 8'($urandom_range(int'(ORDER_MAX) + 1, 255));
      endcase
   endfunction

   function automatic raw_entry_type random_entry();
      raw_entry_type e;
      logic [7:0]    any_attr;
      logic [7:0]    file_attr;
      logic [31:0]   cluster;
      logic [31:0]   size;
      int            roll;
      int            spot;
      any_attr  = 8'($urandom);
      file_attr = any_attr & ~(ATTR_DIR | ATTR_VOL);
      cluster   = ($urandom_range(2) == 0) ? 32'($urandom_range(3)) : 32'($urandom);
      case ($urandom_range(9))
         0:       size = '0;
         1:       size = '1;
         default: size = 32'($urandom);
      endcase
      roll = $urandom_range(99);
      if (roll < 18) begin
         e = build_entry(8'($urandom_range(1, ORDER_MAX)),
                         ($urandom_range(3) == 0) ? any_attr : ATTR_LONG, cluster, size);
      end else if (roll < 40) begin
         e = build_entry(pick_order(), file_attr, cluster, size);
      end else if (roll < 52) begin
         e = with_target_name(build_entry(8'h00, file_attr, cluster, size));
         if ($urandom_range(3) == 0) begin
            spot    = $urandom_range(NAME_LEN - 1);
            e[spot] = e[spot] ^ 8'(1 << $urandom_range(7));
         end
      end else if (roll < 64) begin
         e = build_entry(pick_order(), (any_attr | ATTR_DIR) & ~ATTR_VOL, cluster, size);
      end else if (roll < 72) begin
         // stray long-name attribute lands here too
         e = build_entry(pick_order(),
                         ($urandom_range(1) == 0) ? ATTR_LONG
                                                  : ((any_attr | ATTR_VOL) & ~ATTR_DIR),
                         cluster, size);
      end else if (roll < 75) begin
         e = build_entry(pick_order(), any_attr | ATTR_DIR | ATTR_VOL, cluster, size);
      end else if (roll < 79) begin
         e = build_entry(8'h00, any_attr, cluster, size);
      end else begin
         e = build_entry(8'($urandom), any_attr, cluster, size);
      end
      return e;
   endfunction

   task automatic push_entry(raw_entry_type e, logic sof_first, int nbytes);
      for (int k = 0; k < nbytes; k++) begin
         byte_q.push_back('{sof: sof_first && k == 0, data: e[k]});
         items_sent++;
      end
   endtask

   task automatic push_sector(int max_entries);
      int n;
      n = ($urandom_range(2) == 0) ? DEF_ENTRIES_PER_SECTOR
                                   : $urandom_range(1, DEF_ENTRIES_PER_SECTOR);
      if (n > max_entries) n = max_entries;
      for (int i = 0; i < n; i++) push_entry(random_entry(), i == 0, 32);
      // trailing bytes: ignored after a full sector, a restart mid-entry otherwise
      if ($urandom_range(4) < 2) push_entry(random_entry(), 1'b0, $urandom_range(1, 31));
   endtask

   task automatic wait_drained();
      while (byte_q.size() != 0 || req_tvalid || entry_q.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(logic [63:0] head, logic [23:0] tail, logic [31:0] part,
                              logic [15:0] reserved, logic [31:0] fat_len,
                              logic [7:0] copies, logic [7:0] cls_sect);
      wait_drained();
      settle();
      csr_write(CSR_NAME_HEAD, head);
      csr_write(CSR_NAME_TAIL, 64'(tail));
      csr_write(CSR_PART,      64'(part));
      csr_write(CSR_RESERVED,  64'(reserved));
      csr_write(CSR_FAT_LEN,   64'(fat_len));
      csr_write(CSR_FAT_COPY,  64'(copies));
      csr_write(CSR_CLS_SECT,  64'(cls_sect));
      settle();
   endtask

   task automatic run_phase(int send_pct, int stall_pct, int goal, logic long_hold);
      int   goal_end;
      int   half;
      logic paused;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      if (long_hold) rsp_hold_seq++;
      goal_end = items_sent + goal;
      half     = items_sent + goal / 2;
      paused   = 1'b0;
      while (items_sent < goal_end) begin
         push_sector((goal_end - items_sent + 31) / 32);
         while (byte_q.size() > 48) @(posedge clock);
         if (!paused && items_sent >= half) begin
            // sender stops until every entry result is back
            paused = 1'b1;
            wait_drained();
         end
      end
      wait_drained();
   endtask

   initial begin : stimulus
      raw_entry_type e;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bytes with no sector mark after reset, default target name matches
      push_entry(with_target_name(build_entry(8'h00, ATTR_PLAIN, 32'd2, '1)), 1'b0, 32);
      e = with_target_name(build_entry(8'h00, ATTR_PLAIN, 32'd0, 32'd0));
      e[NAME_LEN - 1] = e[NAME_LEN - 1] ^ 8'h01;
      push_entry(e, 1'b0, 32);
      push_entry(build_entry(8'h44, ATTR_DIR, 32'd3, 32'd0), 1'b0, 32);
      push_entry(build_entry(8'h45, ATTR_VOL, 32'd0, 32'd0), 1'b0, 32);
      push_entry(build_entry(ORDER_MAX + 8'd1, ATTR_LONG, 32'd5, 32'd7), 1'b0, 32);
      push_entry(build_entry(DELETED_MARK, ATTR_LONG, 32'd5, 32'd7), 1'b0, 32);
      push_entry(build_entry(DELETED_MARK, ATTR_PLAIN, 32'd1, 32'd1), 1'b0, 32);
      // long-name run, continues on any attribute while the order byte fits
      push_entry(build_entry(ORDER_MAX, ATTR_LONG, 32'd9, 32'd9), 1'b0, 32);
      push_entry(build_entry(8'h01, ATTR_PLAIN, 32'd9, 32'd9), 1'b0, 32);
      push_entry(build_entry(8'h01, ATTR_DIR | ATTR_VOL, 32'd9, 32'd9), 1'b0, 32);
      push_entry(build_entry(ORDER_MAX + 8'd1, ATTR_DIR, 32'd9, 32'd9), 1'b0, 32);
      e = build_entry(8'hFF, ~(ATTR_DIR | ATTR_VOL), '1, '1);
      for (int k = 1; k < NAME_LEN; k++) e[k] = 8'hFF;
      push_entry(e, 1'b0, 32);
      // end entry, rest of the sector ignored
      push_entry(build_entry(8'h00, ATTR_LONG, 32'd4, 32'd4), 1'b0, 32);
      push_entry(build_entry(8'h33, ATTR_PLAIN, 32'd4, 32'd4), 1'b0, 20);
      push_entry(build_entry(8'h41, ATTR_LONG, 32'd6, 32'd6), 1'b1, 32);
      push_entry(build_entry(ORDER_MAX + 8'd1, ATTR_DIR | ATTR_VOL, 32'd6, 32'd6), 1'b0, 32);
      push_entry(build_entry(8'h55, ATTR_PLAIN, 32'd6, 32'd6), 1'b0, 10);
      // restart in the middle of an entry
      push_entry(build_entry(8'h50, ATTR_PLAIN, 32'd8, 32'd8), 1'b1, 10);
      // full sector, then bytes past its end
      for (int i = 0; i < DEF_ENTRIES_PER_SECTOR; i++)
         push_entry(build_entry(8'(8'h60 + i), ATTR_PLAIN, 32'(i), 32'(i)), i == 0, 32);
      push_entry(build_entry(8'h00, ATTR_PLAIN, 32'd0, 32'd0), 1'b0, 32);
      wait_drained();

      load_config('1, '1, '1, '1, '1, '1, '1);
      run_phase(0, 0, PHASE_ITEMS, 1'b0);
      load_config('0, '0, '0, '0, '0, '0, '0);
      run_phase(87, 0, PHASE_ITEMS, 1'b0);
      load_config({32'($urandom), 32'($urandom)}, 24'($urandom), 32'($urandom),
                  16'($urandom), 32'($urandom), 8'($urandom), 8'($urandom));
      run_phase(0, 87, PHASE_ITEMS, 1'b0);
      load_config({32'($urandom), 32'($urandom)}, 24'($urandom), 32'($urandom),
                  16'($urandom), 32'($urandom), 8'($urandom), 8'($urandom));
      run_phase(33, 33, PHASE_ITEMS, 1'b0);
      load_config(64'h5245_4144_4D45_2020, 24'h54_5854, 32'd2048, 16'd32,
                  32'd1000, 8'd2, 8'd8);
      run_phase(0, 0, PHASE_ITEMS, 1'b1);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("[fat32_directory_entry_scanner] OK");
      end else begin
         $display("[fat32_directory_entry_scanner] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(8 * 400000);
      $display("[fat32_directory_entry_scanner] ERROR");
      $finish;
   end

endmodule

### fat32_directory_entry_scanner.f
rtl/core/fds_pkg.sv
rtl/core/fds_csr.sv
rtl/core/fds_parse.sv
rtl/core/fds_out.sv
rtl/core/fat32_directory_entry_scanner.sv
verif/fat32_directory_entry_scanner_tb.sv
